@@ sv/plmir_pkg.sv @@
package plmir_pkg;

  // limiter theta width, unsigned fixed point
  localparam int unsigned THETA_W = 15;
  // density floor width, unsigned Q15.16
  localparam int unsigned FLOOR_W = 31;
  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_THETA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_FLOOR = 2'd1;

  // register reset values
  localparam logic [THETA_W-1:0] THETA_RESET = 15'd24576;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 31'd1;

  // window fill count at which every new cell gives an interface
  localparam logic [1:0] FILL_FULL = 2'd3;

endpackage

@@ sv/plmir_window.sv @@
module plmir_window import plmir_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic signed [VALUE_WIDTH-1:0] cell_value_i,
  input  logic                          line_start_i,
  input  logic                          apply_floor_i,
  input  logic                          take_i,
  output logic                          valid_o,
  output logic signed [VALUE_WIDTH-1:0] w0_o,
  output logic signed [VALUE_WIDTH-1:0] w1_o,
  output logic signed [VALUE_WIDTH-1:0] w2_o,
  output logic signed [VALUE_WIDTH-1:0] w3_o,
  output logic                          floor_en_o
);

  logic signed [VALUE_WIDTH-1:0] w0_q, w1_q, w2_q, w3_q;
  logic signed [VALUE_WIDTH-1:0] w0_d, w1_d, w2_d;
  logic [1:0] fill_q, fill_d, fill_base;
  logic       floor_q, floor_d;
  logic       valid_q, valid_d;
  logic       produce;

  // next window, fill count and floor flag for an accepted cell
  always_comb begin
    fill_base = line_start_i ? '0 : fill_q;
    produce   = (fill_base == FILL_FULL);
    fill_d    = produce ? FILL_FULL : fill_base + 2'd1;
    floor_d   = line_start_i ? apply_floor_i : floor_q;
    if (line_start_i) begin
      w0_d = '0;
      w1_d = '0;
      w2_d = '0;
    end else begin
      w0_d = w1_q;
      w1_d = w2_q;
      w2_d = w3_q;
    end
  end

  // result-pending flag: set by a producing transfer, cleared when taken
  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = produce;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      floor_q <= 1'b0;
      valid_q <= 1'b0;
      w0_q    <= '0;
      w1_q    <= '0;
      w2_q    <= '0;
      w3_q    <= '0;
    end else begin
      valid_q <= valid_d;
      if (accept_i) begin
        fill_q  <= fill_d;
        floor_q <= floor_d;
        w0_q    <= w0_d;
        w1_q    <= w1_d;
        w2_q    <= w2_d;
        w3_q    <= cell_value_i;
      end
    end
  end

  assign valid_o    = valid_q;
  assign w0_o       = w0_q;
  assign w1_o       = w1_q;
  assign w2_o       = w2_q;
  assign w3_o       = w3_q;
  assign floor_en_o = floor_q;

endmodule

@@ sv/plmir_face.sv @@
module plmir_face import plmir_pkg::*; #(
  parameter int unsigned VALUE_WIDTH     = 32,
  parameter int unsigned THETA_FRAC_BITS = 14
) (
  input  logic signed [VALUE_WIDTH-1:0] vm_i,
  input  logic signed [VALUE_WIDTH-1:0] v_i,
  input  logic signed [VALUE_WIDTH-1:0] vp_i,
  input  logic [THETA_W-1:0]            theta_i,
  input  logic [FLOOR_W-1:0]            floor_i,
  input  logic                          floor_en_i,
  output logic signed [VALUE_WIDTH-1:0] face_o
);

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned TF  = THETA_FRAC_BITS;
  localparam int unsigned PW  = W + 2 + ((THETA_W > TF) ? THETA_W : TF);
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned FW  = ((W > FLOOR_W) ? W : FLOOR_W) + 1;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< TF;
  localparam logic signed [SW:0]   HI  = {{(SW - W + 2){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [SW:0]   LO  = ~HI;

  logic signed [W:0]       dl, dr, dc;
  logic signed [THETA_W:0] th_s;
  logic signed [PW-1:0]    sl, sr, sc, mm;
  logic signed [SW-1:0]    rnd, half;
  logic signed [SW:0]      sum;
  logic signed [W-1:0]     sat;
  logic                    below;

  // one-sided and central differences
  assign dl   = $signed({v_i[W-1], v_i})   - $signed({vm_i[W-1], vm_i});
  assign dr   = $signed({vp_i[W-1], vp_i}) - $signed({v_i[W-1], v_i});
  assign dc   = $signed({vp_i[W-1], vp_i}) - $signed({vm_i[W-1], vm_i});
  assign th_s = $signed({1'b0, theta_i});

  // slope candidates scaled by 2^TF
  assign sl = $signed(PW'(dl)) * $signed(PW'(th_s));
  assign sr = $signed(PW'(dr)) * $signed(PW'(th_s));
  assign sc = $signed(PW'(dc)) <<< (TF - 1);

  // generalized minmod: least magnitude when signs agree, else zero
  always_comb begin
    mm = '0;
    if (sl > 0 && sr > 0 && sc > 0) begin
      mm = (sl < sr) ? sl : sr;
      mm = (mm < sc) ? mm : sc;
    end else if (sl < 0 && sr < 0 && sc < 0) begin
      mm = (sl > sr) ? sl : sr;
      mm = (mm > sc) ? mm : sc;
    end
  end

  // half slope back to value scale, round half up
  assign rnd  = $signed(SW'(mm)) + RND;
  assign half = rnd >>> (TF + 1);
  assign sum  = $signed((SW + 1)'(half)) + $signed((SW + 1)'(v_i));

  // saturate, then apply density floor
  always_comb begin
    if (sum > HI) begin
      sat = HI[W-1:0];
    end else if (sum < LO) begin
      sat = LO[W-1:0];
    end else begin
      sat = sum[W-1:0];
    end
    below  = $signed(FW'(sat)) < $signed(FW'({1'b0, floor_i}));
    face_o = (floor_en_i && below) ? $signed(W'(floor_i)) : sat;
  end

endmodule

@@ sv/plm_interface_reconstruction_top.sv @@
// Piecewise-linear interface reconstruction with a generalized minmod limiter.
// Input channel: one cell value per transfer (in_valid_i / in_stall_o), with
//   line_start_i marking the first cell of a line; apply_floor_i is sampled
//   with that first cell and enables the density floor for the whole line.
// Output channel: one left/right interface pair per transfer
//   (out_valid_o / out_stall_i). The first three cells of a line give no
//   output; each later cell gives one pair for the interface behind it.
// Config channel: cfg_valid_i / cfg_ready_o (always ready), index 0 writes
//   slope_theta, index 1 writes density_floor; other indexes are dropped.
//   Write only while no result is outstanding.
// Timing: a result is offered on the output after its cell transfer passes
//   the window register, then the result register. Throughput: one cell
//   per cycle while in_stall_o is low; the limiter for both faces is
//   evaluated combinationally between those registers.
// Reset: window cleared, fill count zero, floor off, theta = 1.5, floor = 1.
// Stall: a stalled result holds; the window register keeps the next result,
//   and in_stall_o rises only when both registers are full and stalled.
module plm_interface_reconstruction_top import plmir_pkg::*; #(
  parameter int unsigned VALUE_WIDTH     = 32,
  parameter int unsigned THETA_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] cell_value_i,
  input  logic                          line_start_i,
  input  logic                          apply_floor_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] left_state_o,
  output logic signed [VALUE_WIDTH-1:0] right_state_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  logic [THETA_W-1:0] theta_q;
  logic [FLOOR_W-1:0] floor_q;
  logic win_valid, win_floor_en, take, res_ready, accept, cfg_wr;
  logic signed [VALUE_WIDTH-1:0] w0, w1, w2, w3;
  logic signed [VALUE_WIDTH-1:0] left_d, right_d, left_q, right_q;
  logic out_valid_q, out_valid_d;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      theta_q <= THETA_RESET;
      floor_q <= FLOOR_RESET;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_SLOPE_THETA:   theta_q <= cfg_data_i[THETA_W-1:0];
        REG_DENSITY_FLOOR: floor_q <= cfg_data_i[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake between window register and result register
  assign res_ready  = !out_valid_q || !out_stall_i;
  assign take       = win_valid && res_ready;
  assign in_stall_o = win_valid && !res_ready;
  assign accept     = in_valid_i && !in_stall_o;

  plmir_window #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cell_value_i (cell_value_i),
    .line_start_i (line_start_i),
    .apply_floor_i(apply_floor_i),
    .take_i       (take),
    .valid_o      (win_valid),
    .w0_o         (w0),
    .w1_o         (w1),
    .w2_o         (w2),
    .w3_o         (w3),
    .floor_en_o   (win_floor_en)
  );

  // left face of the interface: cell w1 toward w2
  plmir_face #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .THETA_FRAC_BITS(THETA_FRAC_BITS)
  ) u_face_left (
    .vm_i      (w0),
    .v_i       (w1),
    .vp_i      (w2),
    .theta_i   (theta_q),
    .floor_i   (floor_q),
    .floor_en_i(win_floor_en),
    .face_o    (left_d)
  );

  // right face of the interface: cell w2 toward w1
  plmir_face #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .THETA_FRAC_BITS(THETA_FRAC_BITS)
  ) u_face_right (
    .vm_i      (w3),
    .v_i       (w2),
    .vp_i      (w1),
    .theta_i   (theta_q),
    .floor_i   (floor_q),
    .floor_en_i(win_floor_en),
    .face_o    (right_d)
  );

  // result register
  assign out_valid_d = res_ready ? win_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_state_o  = left_q;
  assign right_state_o = right_q;

  // the input side only stalls while a result is waiting in the window stage
  a_stall_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> win_valid)
    else $error("input stalled with no pending result");

  // a cell that starts a line never yields a result
  a_line_start_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && line_start_i) |=> !win_valid)
    else $error("line start produced a result");

  // a pending result moved forward is presented on the output next cycle
  a_take_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("taken result not presented");

  // theta write lands in the register
  a_theta_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_index_i == REG_SLOPE_THETA)
      |=> theta_q == $past(cfg_data_i[THETA_W-1:0]))
    else $error("slope theta write lost");

endmodule
